FILE: hw/rtl/bta_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bta_pkg;

    localparam int REQUESTERS  = 16;
    localparam int TICKET_BITS = 16;
    localparam int IDX_W       = (REQUESTERS > 1) ? $clog2(REQUESTERS) : 1;
    localparam int ID_W        = 4;
    localparam int Q_DEPTH     = 2;

    // Operation classes assigned by the front end
    localparam logic [1:0] OP_REQ = 2'd0;
    localparam logic [1:0] OP_REL = 2'd1;
    localparam logic [1:0] OP_NOP = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
    localparam logic [1:0] STAT_NO_TICKET = 2'd2;

    typedef struct packed {
        logic [1:0]      op;
        logic [ID_W-1:0] id;
    } item_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bakery_ticket_arbiter_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Bakery ticket arbiter. Issue a command by raising start while busy is low:
// cmd 0 requests a ticket for requester (one above the largest ticket held,
// the requester's own included), cmd 1 releases its ticket. Exactly one result
// per command comes back on done for a single cycle and cannot be held off,
// so capture it then. status reports ok, a refused request on ticket overflow,
// or a release without a held ticket; ticket_given holds the new ticket (else
// zero); grant_valid and grant_id name the holder of the smallest ticket,
// lower id on ties. Each command is handled in steps: the back end fetches it
// from the command queue, walks the 16-entry ticket table entry by entry for
// the largest and smallest tickets, and commits. A two-entry command queue
// lets a second command be taken while the first is worked on; busy is high
// while that queue is full. After reset the table is empty and the block is
// ready at once.
module bakery_ticket_arbiter_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        cmd,
    input  logic [bta_pkg::ID_W-1:0]    requester,
    output logic                        done,
    output logic [1:0]                  status,
    output logic [15:0]                 ticket_given,
    output logic                        grant_valid,
    output logic [3:0]                  grant_id
);
    import bta_pkg::*;

    item_t  head;
    logic   head_valid;
    logic   take;

    // Front end: classify and queue commands
    bta_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .cmd        (cmd),
        .requester  (requester),
        .busy       (busy),
        .head_valid (head_valid),
        .head       (head),
        .take       (take)
    );

    // Back end: scan the ticket table, update it, report the grant
    bta_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .take         (take),
        .done         (done),
        .status       (status),
        .ticket_given (ticket_given),
        .grant_valid  (grant_valid),
        .grant_id     (grant_id)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/bta_front.sv
`timescale 1ns / 1ps
`default_nettype none

module bta_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        cmd,
    input  logic [bta_pkg::ID_W-1:0]    requester,
    output logic                        busy,
    output logic                        head_valid,
    output bta_pkg::item_t              head,
    input  logic                        take
);
    import bta_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    item_t              q_reg [Q_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push;
    logic               pop;
    item_t              in_item;

    // Classify: out-of-range ids become no-ops
    always_comb
    begin
        in_item.id = requester;
        if (int'(requester) >= REQUESTERS)
        begin
            in_item.op = OP_NOP;
        end
        else if (cmd)
        begin
            in_item.op = OP_REL;
        end
        else
        begin
            in_item.op = OP_REQ;
        end
    end

    assign busy       = (count_reg == CNT_W'(Q_DEPTH));
    assign push       = start && !busy;
    assign head_valid = (count_reg != '0);
    assign pop        = take && head_valid;
    assign head       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(Q_DEPTH))
        else $error("queue count above depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> head_valid)
        else $error("take while queue empty");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not advance on push");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/bta_back.sv
`timescale 1ns / 1ps
`default_nettype none

module bta_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    head_valid,
    input  bta_pkg::item_t          head,
    output logic                    take,
    output logic                    done,
    output logic [1:0]              status,
    output logic [15:0]             ticket_given,
    output logic                    grant_valid,
    output logic [3:0]              grant_id
);
    import bta_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [TICKET_BITS-1:0] TICKET_MAX = '1;

    logic [1:0]             state_reg, state_next;
    logic [IDX_W-1:0]       cnt_reg;
    item_t                  item_reg;
    logic [TICKET_BITS-1:0] max_reg;
    logic [TICKET_BITS-1:0] own_reg;
    logic [TICKET_BITS-1:0] omin_reg;
    logic [IDX_W-1:0]       owho_reg;
    logic                   ofound_reg;
    logic [TICKET_BITS-1:0] table_reg [REQUESTERS];

    logic                   done_reg;
    logic [1:0]             status_reg;
    logic [15:0]            given_reg;
    logic                   gvalid_reg;
    logic [3:0]             gid_reg;

    logic [TICKET_BITS-1:0] cur;
    logic                   is_own;
    logic [IDX_W-1:0]       item_idx;

    logic [1:0]             fin_status;
    logic [TICKET_BITS-1:0] fin_given;
    logic                   fin_valid;
    logic [IDX_W-1:0]       fin_who;
    logic                   wr_en;
    logic [TICKET_BITS-1:0] wr_val;
    logic                   own_wins;

    assign item_idx = IDX_W'(item_reg.id);
    assign cur      = table_reg[cnt_reg];
    assign is_own   = (item_reg.op != OP_NOP) && (cnt_reg == item_idx);
    assign take     = (state_reg == ST_IDLE) && head_valid;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == IDX_W'(REQUESTERS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Own entry beats the best of the others when the table is left unchanged
    assign own_wins = (own_reg != '0) &&
                      (!ofound_reg || (own_reg < omin_reg) ||
                       ((own_reg == omin_reg) && (item_idx < owho_reg)));

    always_comb
    begin
        fin_status = STAT_OK;
        fin_given  = '0;
        wr_en      = 1'b0;
        wr_val     = '0;
        fin_valid  = ofound_reg;
        fin_who    = owho_reg;
        case (item_reg.op)
            OP_REQ:
            begin
                if (max_reg == TICKET_MAX)
                begin
                    fin_status = STAT_OVERFLOW;
                    if (own_wins)
                    begin
                        fin_valid = 1'b1;
                        fin_who   = item_idx;
                    end
                end
                else
                begin
                    // New ticket exceeds every other, so it wins only when alone
                    fin_given = max_reg + 1'b1;
                    wr_en     = 1'b1;
                    wr_val    = fin_given;
                    if (!ofound_reg)
                    begin
                        fin_valid = 1'b1;
                        fin_who   = item_idx;
                    end
                end
            end
            OP_REL:
            begin
                if (own_reg == '0)
                begin
                    fin_status = STAT_NO_TICKET;
                end
                else
                begin
                    wr_en = 1'b1;
                end
            end
            default:
            begin
                fin_status = STAT_OK;
            end
        endcase
        if (!fin_valid)
        begin
            fin_who = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            for (int i = 0; i < REQUESTERS; i++)
            begin
                table_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_DONE);
            if ((state_reg == ST_DONE) && wr_en)
            begin
                table_reg[item_idx] <= wr_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                item_reg   <= head;
                cnt_reg    <= '0;
                max_reg    <= '0;
                own_reg    <= '0;
                omin_reg   <= '0;
                owho_reg   <= '0;
                ofound_reg <= 1'b0;
            end
            ST_SCAN:
            begin
                if (cur > max_reg)
                begin
                    max_reg <= cur;
                end
                if (is_own)
                begin
                    own_reg <= cur;
                end
                else if ((cur != '0) && (!ofound_reg || (cur < omin_reg)))
                begin
                    ofound_reg <= 1'b1;
                    omin_reg   <= cur;
                    owho_reg   <= cnt_reg;
                end
                if (cnt_reg != IDX_W'(REQUESTERS - 1))
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                status_reg <= fin_status;
                given_reg  <= 16'(fin_given);
                gvalid_reg <= fin_valid;
                gid_reg    <= 4'(fin_who);
            end
            default:
            begin
                cnt_reg <= '0;
            end
        endcase
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign ticket_given = given_reg;
    assign grant_valid  = gvalid_reg;
    assign grant_id     = gid_reg;

`ifndef ASSERT_OFF
    a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == ST_DONE)
        else $error("result strobe without a finish cycle");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == STAT_OK || status == STAT_OVERFLOW ||
                  status == STAT_NO_TICKET))
        else $error("status code out of range");

    a_no_grant_id: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !grant_valid) |-> grant_id == '0)
        else $error("grant id set without a grant");

    a_given_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ticket_given != '0) |-> (status == STAT_OK && grant_valid))
        else $error("ticket given on a failed command");
`endif

endmodule

`default_nettype wire
